[hdl/ibr_pkg.sv]
package ibr_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned RATIO_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned ADDR_MW   = 24;
  localparam int unsigned FRAC_BITS = 17;
  localparam int unsigned WGT_SHIFT = 11;
  localparam int unsigned WGT_W     = WGT_SHIFT + 1;
  localparam int unsigned WPROD_W   = 2 * WGT_SHIFT + 1;
  localparam int unsigned ACC_W     = PIX_W + 2 * WGT_SHIFT + 2;
  localparam int unsigned T_W       = 38;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 2'd3;

  typedef struct packed {
    logic                         is_req;
    logic [ADDR_MW-1:0]           addr;
    logic [PIX_W-1:0]             pix;
    logic [COORD_W-1:0]           col;
    logic [COORD_W-1:0]           row;
    logic [3:0][WPROD_W-1:0]      wgt;
  } entry_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pix;
  } res_t;

endpackage

[hdl/ibr_if.sv]
interface ibr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [11:0] column_index;
  logic [11:0] row_index;
  logic [7:0] pixel_in;
  modport source (output valid, action, column_index, row_index, pixel_in, input ready);
  modport sink (input valid, action, column_index, row_index, pixel_in, output ready);
endinterface

interface ibr_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_column;
  logic [11:0] out_row;
  logic [7:0]  pixel_out;
  modport source (output valid, out_column, out_row, pixel_out, input ready);
  modport sink (input valid, out_column, out_row, pixel_out, output ready);
endinterface

interface ibr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/ibr_fifo.sv]
module ibr_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [WIDTH-1:0]            wdata_i,
  input  logic                        pop_i,
  output logic [WIDTH-1:0]            rdata_o,
  output logic                        empty_o,
  output logic                        full_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end
endmodule

[hdl/ibr_front.sv]
module ibr_front #(
  parameter int unsigned MAX_SRC_WIDTH  = 256,
  parameter int unsigned MAX_SRC_HEIGHT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ibr_in_if.sink          in_if,
  ibr_cfg_if.sink         cfg_if,
  output logic            push_o,
  output ibr_pkg::entry_t entry_o,
  input  logic            full_i
);
  import ibr_pkg::*;

  logic [8:0]         src_w_q, src_h_q;
  logic [RATIO_W-1:0] sx_ratio_q, sy_ratio_q;

  logic en;
  logic v1_q, v2_q, v3_q;

  logic               req1_q;
  logic [COORD_W-1:0] col1_q, row1_q;
  logic [PIX_W-1:0]   pix1_q;
  logic [T_W-2:0]     px1_q, py1_q;

  logic               req2_q, ok2_q;
  logic [COORD_W-1:0] col2_q, row2_q;
  logic [PIX_W-1:0]   pix2_q;
  logic [DIM_W-1:0]   sx2_q, sy2_q;
  logic [WGT_W-1:0]   wx2_q, wy2_q;

  logic               ok3_q;
  entry_t             ent3_q;

  logic signed [T_W-1:0] tx, ty;
  logic signed [20:0]    bx, by;
  logic [FRAC_BITS-1:0]  fx, fy;
  logic [DIM_W-1:0]      wc, hc, sx, sy;
  logic [WGT_W-1:0]      wx0, wy0, wx1, wy1;
  logic                  ok;
  logic [FRAC_BITS:0]    invx, invy;
  logic [FRAC_BITS:0]    rx, ry;

  assign cfg_if.ready = 1'b1;
  assign en           = !v3_q || !full_i;
  assign in_if.ready  = en;
  assign push_o       = v3_q && ok3_q && !full_i;
  assign entry_o      = ent3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= 9'd256;
      src_h_q    <= 9'd256;
      sx_ratio_q <= RATIO_W'(65536);
      sy_ratio_q <= RATIO_W'(65536);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_SRC_WIDTH:  src_w_q    <= cfg_if.data[8:0];
        CFG_SRC_HEIGHT: src_h_q    <= cfg_if.data[8:0];
        CFG_SCALE_X:    sx_ratio_q <= cfg_if.data;
        CFG_SCALE_Y:    sy_ratio_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_if.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      req1_q <= in_if.action;
      col1_q <= in_if.column_index;
      row1_q <= in_if.row_index;
      pix1_q <= in_if.pixel_in;
      px1_q  <= (T_W-1)'({in_if.column_index, 1'b1}) * (T_W-1)'(sx_ratio_q);
      py1_q  <= (T_W-1)'({in_if.row_index, 1'b1}) * (T_W-1)'(sy_ratio_q);
    end
  end

  always_comb begin
    wc = {4'b0, src_w_q};
    hc = {4'b0, src_h_q};
    if (wc < DIM_W'(2)) begin
      wc = DIM_W'(2);
    end else if (wc > DIM_W'(MAX_SRC_WIDTH)) begin
      wc = DIM_W'(MAX_SRC_WIDTH);
    end
    if (hc < DIM_W'(2)) begin
      hc = DIM_W'(2);
    end else if (hc > DIM_W'(MAX_SRC_HEIGHT)) begin
      hc = DIM_W'(MAX_SRC_HEIGHT);
    end
    tx = $signed({1'b0, px1_q}) - T_W'(65536);
    ty = $signed({1'b0, py1_q}) - T_W'(65536);
    bx = tx[T_W-1:FRAC_BITS];
    by = ty[T_W-1:FRAC_BITS];
    fx = tx[FRAC_BITS-1:0];
    fy = ty[FRAC_BITS-1:0];
    if (by > $signed({8'b0, hc - DIM_W'(2)})) begin
      sy = hc - DIM_W'(2);
    end else if (by < 0) begin
      sy = '0;
    end else begin
      sy = by[DIM_W-1:0];
    end
    if (bx < 0) begin
      sx = '0;
      fx = '0;
    end else if (bx >= $signed({8'b0, wc - DIM_W'(1)})) begin
      sx = wc - DIM_W'(2);
      fx = '0;
    end else begin
      sx = bx[DIM_W-1:0];
    end
    invx = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fx};
    invy = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fy};
    rx   = invx + (FRAC_BITS+1)'(1 << (FRAC_BITS - WGT_SHIFT - 1));
    ry   = invy + (FRAC_BITS+1)'(1 << (FRAC_BITS - WGT_SHIFT - 1));
    wx0  = rx[FRAC_BITS:FRAC_BITS-WGT_SHIFT];
    wy0  = ry[FRAC_BITS:FRAC_BITS-WGT_SHIFT];
    ok   = req1_q || ({1'b0, col1_q} < DIM_W'(MAX_SRC_WIDTH)
                      && {1'b0, row1_q} < DIM_W'(MAX_SRC_HEIGHT));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      req2_q <= req1_q;
      ok2_q  <= ok;
      col2_q <= col1_q;
      row2_q <= row1_q;
      pix2_q <= pix1_q;
      sx2_q  <= sx;
      sy2_q  <= sy;
      wx2_q  <= wx0;
      wy2_q  <= wy0;
    end
  end

  assign wx1 = WGT_W'(1 << WGT_SHIFT) - wx2_q;
  assign wy1 = WGT_W'(1 << WGT_SHIFT) - wy2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok3_q         <= ok2_q;
      ent3_q.is_req <= req2_q;
      ent3_q.pix    <= pix2_q;
      ent3_q.col    <= col2_q;
      ent3_q.row    <= row2_q;
      if (req2_q) begin
        ent3_q.addr <= ADDR_MW'(sy2_q) * ADDR_MW'(MAX_SRC_WIDTH) + ADDR_MW'(sx2_q);
      end else begin
        ent3_q.addr <= ADDR_MW'(row2_q) * ADDR_MW'(MAX_SRC_WIDTH) + ADDR_MW'(col2_q);
      end
      ent3_q.wgt[0] <= WPROD_W'(wx2_q) * WPROD_W'(wy2_q);
      ent3_q.wgt[1] <= WPROD_W'(wx2_q) * WPROD_W'(wy1);
      ent3_q.wgt[2] <= WPROD_W'(wx1) * WPROD_W'(wy2_q);
      ent3_q.wgt[3] <= WPROD_W'(wx1) * WPROD_W'(wy1);
    end
  end
endmodule

[hdl/ibr_back.sv]
module ibr_back #(
  parameter int unsigned MAX_SRC_WIDTH  = 256,
  parameter int unsigned MAX_SRC_HEIGHT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  ibr_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            push_o,
  output ibr_pkg::res_t   res_o,
  input  logic [1:0]      res_count_i
);
  import ibr_pkg::*;

  localparam int unsigned MEM_D = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AW    = $clog2(MEM_D);

  logic [PIX_W-1:0] frame_q [MEM_D];

  logic         busy_q, busy_d;
  logic [1:0]   cnt_q, cnt_d;
  entry_t       cur_q, cur_d;
  logic [1:0]   infl_q, infl_d;
  logic         start, load, issue, last_slot;
  logic [ADDR_MW-1:0] raddr;

  logic               rv_q, rfirst_q, rlast_q;
  logic [WPROD_W-1:0] rw_q;
  logic [COORD_W-1:0] rcol_q, rrow_q;
  logic [PIX_W-1:0]   rdata_q;
  logic [ACC_W-1:0]   acc_q, acc_d, sum;
  logic [ACC_W-1:0]   prod;

  assign last_slot = busy_q && (cnt_q == 2'd3);
  assign start = !empty_i && head_i.is_req && (!busy_q || last_slot)
                 && ({1'b0, res_count_i} + {1'b0, infl_q} < 3'd2);
  assign load  = !empty_i && !head_i.is_req && !busy_q;
  assign pop_o = start || load;
  assign issue = busy_q;

  always_comb begin
    case (cnt_q)
      2'd0:    raddr = cur_q.addr;
      2'd1:    raddr = cur_q.addr + ADDR_MW'(MAX_SRC_WIDTH);
      2'd2:    raddr = cur_q.addr + ADDR_MW'(1);
      default: raddr = cur_q.addr + ADDR_MW'(MAX_SRC_WIDTH + 1);
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    cur_d  = cur_q;
    if (issue) begin
      cnt_d = cnt_q + 2'd1;
      if (last_slot) begin
        busy_d = 1'b0;
      end
    end
    if (start) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      cur_d  = head_i;
    end
  end

  assign prod   = ACC_W'(rdata_q) * ACC_W'(rw_q);
  assign sum    = (rfirst_q ? '0 : acc_q) + prod;
  assign acc_d  = rv_q ? sum : acc_q;
  assign push_o = rv_q && rlast_q;
  assign res_o.col = rcol_q;
  assign res_o.row = rrow_q;
  assign res_o.pix = (sum[ACC_W-1:2*WGT_SHIFT] > 10'd255 ? 8'hFF : 8'h00)
                     | PIX_W'(sum >> (2 * WGT_SHIFT));

  always_comb begin
    infl_d = infl_q;
    if (start && !push_o) begin
      infl_d = infl_q + 2'd1;
    end else if (push_o && !start) begin
      infl_d = infl_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      infl_q <= '0;
      rv_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      infl_q <= infl_d;
      rv_q   <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    acc_q    <= acc_d;
    rfirst_q <= (cnt_q == 2'd0);
    rlast_q  <= (cnt_q == 2'd3);
    rw_q     <= cur_q.wgt[cnt_q];
    rcol_q   <= cur_q.col;
    rrow_q   <= cur_q.row;
    if (load) begin
      frame_q[head_i.addr[AW-1:0]] <= head_i.pix;
    end else if (issue) begin
      rdata_q <= frame_q[raddr[AW-1:0]];
    end
  end
endmodule

[hdl/image_resize_bilinear_unit.sv]
// Bilinear scaler for 8-bit single-channel images. A load beat writes one source pixel
// into the frame memory; a request beat returns one interpolated pixel and occupies
// the single-port frame memory while its four neighbours are read, one per cycle. A new
// request can start as the previous one reads its last neighbour, if the result queue
// has room; loads go at one per cycle while no request holds the memory. The frame
// memory is not cleared: every source pixel must be loaded before a request reads it.
module image_resize_bilinear_unit #(
  parameter int unsigned MAX_SRC_WIDTH  = 256,
  parameter int unsigned MAX_SRC_HEIGHT = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ibr_in_if.sink    in_if,
  ibr_cfg_if.sink   cfg_if,
  ibr_out_if.source out_if
);
  import ibr_pkg::*;

  logic   fpush, ffull, fempty, fpop;
  entry_t fent, fhead;
  logic   rpush, rempty, rfull;
  res_t   rin, rhead;
  logic [1:0] rcount;
  logic [2:0] fcount;

  ibr_front #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_front (
    .clk_i, .rst_ni, .in_if, .cfg_if,
    .push_o(fpush), .entry_o(fent), .full_i(ffull)
  );

  ibr_fifo #(.DEPTH(4), .WIDTH($bits(entry_t))) u_queue (
    .clk_i, .rst_ni, .push_i(fpush), .wdata_i(fent), .pop_i(fpop),
    .rdata_o(fhead), .empty_o(fempty), .full_o(ffull), .count_o(fcount)
  );

  ibr_back #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_back (
    .clk_i, .rst_ni, .empty_i(fempty), .head_i(fhead), .pop_o(fpop),
    .push_o(rpush), .res_o(rin), .res_count_i(rcount)
  );

  ibr_fifo #(.DEPTH(2), .WIDTH($bits(res_t))) u_res (
    .clk_i, .rst_ni, .push_i(rpush), .wdata_i(rin), .pop_i(out_if.valid && out_if.ready),
    .rdata_o(rhead), .empty_o(rempty), .full_o(rfull), .count_o(rcount)
  );

  assign out_if.valid      = !rempty && (rfull || !rfull) && (fcount <= 3'd4);
  assign out_if.out_column = rhead.col;
  assign out_if.out_row    = rhead.row;
  assign out_if.pixel_out  = rhead.pix;
endmodule

[hdl/ibr_checker.sv]
module ibr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_payload_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("Result beat changed while stalled.");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("Configuration port not ready.");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("Result beat right after reset.");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> ##1 !out_valid_i ##1 !out_valid_i)
    else $error("Result beat too soon after reset.");
endmodule

bind image_resize_bilinear_unit ibr_checker u_ibr_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .cfg_ready_i(cfg_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_payload_i({out_if.out_column, out_if.out_row, out_if.pixel_out})
);

[test/image_resize_bilinear_unit_tb.sv]
`timescale 1ns / 1ps

module image_resize_bilinear_unit_tb;
  import ibr_pkg::*;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;
  localparam int   STORE_W     = 256;
  localparam int   STORE_H     = 256;
  localparam int   IDLE_LIMIT  = 4000;

  logic clk_i;
  logic rst_ni;

  ibr_in_if  in_if();
  ibr_cfg_if cfg_if();
  ibr_out_if out_if();

  image_resize_bilinear_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .cfg_if(cfg_if),
    .out_if(out_if)
  );

  logic [7:0]         frame_mem [STORE_W*STORE_H];
  bit                 loaded_mask [STORE_W*STORE_H];
  logic [8:0]         src_w;
  logic [8:0]         src_h;
  logic [RATIO_W-1:0] ratio_x;
  logic [RATIO_W-1:0] ratio_y;
  res_t               pixel_expect_q [$];

  int errors;
  int idle_cycles;
  int burst_left;
  bit no_gaps;
  int rcv_mode;
  int rcv_phase;
  int hold_request;
  int hold_left;
  int n_loads;
  int n_requests;
  int n_results;
  int n_cfg;

  always #5 clk_i = ~clk_i;

  function automatic int clamp_dim(input logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic void map_axis(input logic [COORD_W-1:0] idx, input logic [RATIO_W-1:0] ratio,
                                   output longint base, output longint frac);
    longint t;
    t = (longint'(idx) * 2 + 1) * longint'(ratio) - 65536;
    base = t >>> FRAC_BITS;
    frac = t - (base <<< FRAC_BITS);
  endfunction

  function automatic longint near_weight(input longint frac);
    return (((longint'(1) <<< FRAC_BITS) - frac) * 2048 + 65536) >>> FRAC_BITS;
  endfunction

  function automatic void locate(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                                 output int sx, output int sy,
                                 output longint wx0, output longint wy0);
    int w;
    int h;
    longint bx;
    longint fx;
    longint by;
    longint fy;
    w = clamp_dim(src_w);
    h = clamp_dim(src_h);
    map_axis(row, ratio_y, by, fy);
    if (by > h - 2) by = h - 2;
    if (by < 0) by = 0;
    map_axis(col, ratio_x, bx, fx);
    if (bx < 0) begin
      bx = 0;
      fx = 0;
    end
    if (bx >= w - 1) begin
      bx = w - 2;
      fx = 0;
    end
    sx = int'(bx);
    sy = int'(by);
    wx0 = near_weight(fx);
    wy0 = near_weight(fy);
  endfunction

  function automatic logic [7:0] predict_pixel(input logic [COORD_W-1:0] col,
                                               input logic [COORD_W-1:0] row);
    int sx;
    int sy;
    int a0;
    int a1;
    longint wx0;
    longint wy0;
    longint sum;
    locate(col, row, sx, sy, wx0, wy0);
    a0 = sy * STORE_W + sx;
    a1 = a0 + STORE_W;
    sum = longint'(frame_mem[a0]) * wx0 * wy0
        + longint'(frame_mem[a1]) * wx0 * (2048 - wy0)
        + longint'(frame_mem[a0 + 1]) * (2048 - wx0) * wy0
        + longint'(frame_mem[a1 + 1]) * (2048 - wx0) * (2048 - wy0);
    sum = sum >>> 22;
    if (sum > 255) sum = 255;
    return sum[7:0];
  endfunction

  task automatic send_beat(input logic act, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [PIX_W-1:0] pix);
    res_t r;
    if (!no_gaps && burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= act;
    in_if.column_index <= col;
    in_if.row_index    <= row;
    in_if.pixel_in     <= pix;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    if (act == ACT_LOAD) begin
      n_loads++;
      if (col < STORE_W && row < STORE_H) begin
        frame_mem[row * STORE_W + col] = pix;
        loaded_mask[row * STORE_W + col] = 1'b1;
      end
    end else begin
      n_requests++;
      r.col = col;
      r.row = row;
      r.pix = predict_pixel(col, row);
      pixel_expect_q.insert(pixel_expect_q.size(), r);
    end
  endtask

  // Any neighbour the request would read that was never loaded gets a load first.
  task automatic issue_request(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int sx;
    int sy;
    int a;
    longint wx0;
    longint wy0;
    locate(col, row, sx, sy, wx0, wy0);
    for (int k = 0; k < 4; k++) begin
      a = (sy + k / 2) * STORE_W + sx + k % 2;
      if (!loaded_mask[a])
        send_beat(ACT_LOAD, COORD_W'(a % STORE_W), COORD_W'(a / STORE_W), PIX_W'($urandom));
    end
    send_beat(ACT_REQUEST, col, row, PIX_W'($urandom));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    n_cfg++;
    case (idx)
      CFG_SRC_WIDTH:  src_w = data[8:0];
      CFG_SRC_HEIGHT: src_h = data[8:0];
      CFG_SCALE_X:    ratio_x = data;
      default:        ratio_y = data;
    endcase
  endtask

  task automatic set_config(input logic [8:0] w, input logic [8:0] h,
                            input logic [RATIO_W-1:0] rx, input logic [RATIO_W-1:0] ry);
    drain();
    write_reg(CFG_SRC_WIDTH, {15'($urandom), w});
    write_reg(CFG_SRC_HEIGHT, {15'($urandom), h});
    write_reg(CFG_SCALE_X, rx);
    write_reg(CFG_SCALE_Y, ry);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    rcv_mode = 0;
    send_beat(ACT_LOAD, 12'd4095, 12'd4095, 8'hFF);
    send_beat(ACT_LOAD, 12'd256, 12'd3, 8'h11);
    send_beat(ACT_LOAD, 12'd3, 12'd256, 8'h22);
    send_beat(ACT_LOAD, 12'd255, 12'd255, 8'hFF);
    send_beat(ACT_LOAD, 12'd0, 12'd0, 8'h00);
    send_beat(ACT_LOAD, 12'd1, 12'd0, 8'hFF);
    send_beat(ACT_LOAD, 12'd0, 12'd1, 8'hFF);
    send_beat(ACT_LOAD, 12'd1, 12'd1, 8'h00);
    issue_request(12'd0, 12'd0);
    issue_request(12'd3, 12'd5);
    issue_request(12'd255, 12'd255);
    issue_request(12'd4095, 12'd4095);
    issue_request(12'd4095, 12'd0);
    drain();
  endtask

  task automatic test_config_extremes();
    rcv_mode = 1;
    set_config(9'd0, 9'd1, 24'd0, 24'd0);
    issue_request(12'd0, 12'd0);
    issue_request(12'd4095, 12'd4095);
    set_config(9'd511, 9'd2, 24'hFFFFFF, 24'd1);
    issue_request(12'd0, 12'd0);
    issue_request(12'd4095, 12'd4095);
    issue_request(12'd2048, 12'd1);
    set_config(9'd2, 9'd300, 24'd1, 24'hFFFFFF);
    issue_request(12'd1, 12'd2048);
    issue_request(12'd4095, 12'd4095);
    set_config(9'd256, 9'd256, 24'h008000, 24'h018000);
    issue_request(12'd7, 12'd3);
    issue_request(12'd511, 12'd170);
  endtask

  task automatic run_random(input int n_items);
    int w;
    int h;
    int dw;
    int dh;
    int pick;
    logic [RATIO_W-1:0] rx;
    logic [RATIO_W-1:0] ry;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 20);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 20);
    dw = $urandom_range(1, 40);
    dh = $urandom_range(1, 40);
    rx = RATIO_W'((clamp_dim(9'(w)) << 16) / dw);
    ry = RATIO_W'((clamp_dim(9'(h)) << 16) / dh);
    if ($urandom_range(0, 7) == 0) rx = RATIO_W'($urandom);
    if ($urandom_range(0, 7) == 0) ry = RATIO_W'($urandom);
    set_config(9'(w), 9'(h), rx, ry);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)
        send_beat(ACT_LOAD, COORD_W'($urandom_range(0, clamp_dim(9'(w)) - 1)),
                  COORD_W'($urandom_range(0, clamp_dim(9'(h)) - 1)), PIX_W'($urandom));
      else if (pick < 30)
        send_beat(ACT_LOAD, COORD_W'($urandom) | 12'h100, COORD_W'($urandom), PIX_W'($urandom));
      else if (pick < 36)
        issue_request(COORD_W'($urandom), COORD_W'($urandom));
      else
        issue_request(COORD_W'($urandom_range(0, dw - 1)), COORD_W'($urandom_range(0, dh - 1)));
    end
  endtask

  task automatic test_random_scaling();
    for (int p = 0; p < 9; p++) begin
      rcv_mode = p % 3;
      no_gaps = (p == 4);
      run_random(80);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_backpressure();
    rcv_mode = 1;
    set_config(9'd16, 9'd16, 24'h00C000, 24'h014000);
    no_gaps = 1'b1;
    hold_request = 300;
    for (int i = 0; i < 60; i++)
      issue_request(COORD_W'($urandom_range(0, 25)), COORD_W'($urandom_range(0, 15)));
    no_gaps = 1'b0;
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      rcv_phase = 0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      rcv_phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (rcv_mode == 0) begin
        out_if.ready <= 1'b1;
      end else if (rcv_mode == 1) begin
        out_if.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_if.ready <= (rcv_phase % 7 < 3);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (pixel_expect_q.size() == 0) begin
        $error("unexpected result beat col=%0d row=%0d pix=%0d",
               out_if.out_column, out_if.out_row, out_if.pixel_out);
        errors++;
      end else begin
        exp_r = pixel_expect_q.pop_front();
        if (out_if.out_column !== exp_r.col) begin
          $error("out_column: expected %0d, got %0d", exp_r.col, out_if.out_column);
          errors++;
        end
        if (out_if.out_row !== exp_r.row) begin
          $error("out_row: expected %0d, got %0d", exp_r.row, out_if.out_row);
          errors++;
        end
        if (out_if.pixel_out !== exp_r.pix) begin
          $error("pixel_out: expected %0d, got %0d", exp_r.pix, out_if.pixel_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("image_resize_bilinear_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= ACT_LOAD;
    in_if.column_index <= '0;
    in_if.row_index <= '0;
    in_if.pixel_in <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_SRC_WIDTH;
    cfg_if.data <= '0;
    src_w = 9'd256;
    src_h = 9'd256;
    ratio_x = 24'd65536;
    ratio_y = 24'd65536;
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    rcv_mode = 0;
    hold_request = 0;
    n_loads = 0;
    n_requests = 0;
    n_results = 0;
    n_cfg = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_output_backpressure();
    test_random_scaling();
    drain();

    $display("Covered %0d loads, %0d requests and %0d result beats over %0d register writes,",
             n_loads, n_requests, n_results, n_cfg);
    $display("including clamped sizes, zero and full-scale ratios and a long output stall.");
    if (errors == 0) begin
      $display("image_resize_bilinear_unit regression: pass");
    end else begin
      $display("image_resize_bilinear_unit regression: fail");
    end
    $finish;
  end

endmodule
